[hw/rtl/mft_pkg.sv]
// Package for the motor feedback multiturn tracker.
// Holds the field widths, register indexes, protocol codes and shared structs.
// No dependencies; every other file of the block uses it by scoped names.
package mft_pkg;

  localparam int unsigned MOTOR_SLOTS = 2;
  localparam int unsigned SLOT_W      = $clog2(MOTOR_SLOTS);

  localparam int unsigned ENC_W       = 13;
  localparam int unsigned TURN_W      = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TOTAL_W     = TURN_W + ENC_W;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned MOTOR_W     = 3;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned BUS_W       = 2;
  localparam int unsigned PAYLOAD_W   = 56;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Half a mechanical turn in encoder counts; larger jumps are wraps.
  localparam logic signed [ENC_W:0] ENC_HALF_TURN = (ENC_W + 1)'(4096);

  localparam logic [BUS_W-1:0] BUS_FEEDBACK = BUS_W'(2);

  localparam logic ACTION_FRAME = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  localparam logic [ID_W-1:0]    RST_ID_BASE  = ID_W'(516);
  localparam logic [MOTOR_W-1:0] RST_YAW_ID   = MOTOR_W'(1);
  localparam logic [MOTOR_W-1:0] RST_PITCH_ID = MOTOR_W'(2);
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = TIMEOUT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YAW_ID   = 2'd0,
    REG_PITCH_ID = 2'd1,
    REG_ID_BASE  = 2'd2,
    REG_TIMEOUT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MOTOR_W-1:0]   yaw_id;
    logic [MOTOR_W-1:0]   pitch_id;
    logic [ID_W-1:0]      id_base;
    logic [TIMEOUT_W-1:0] timeout;
  } mft_cfg_t;

  // Decoded feedback frame; hit is set only when a slot should be updated.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_W-1:0]     slot;
    logic [ENC_W-1:0]      enc;
    logic [WORD_W-1:0]     speed;
    logic [WORD_W-1:0]     current;
    logic [BYTE_W-1:0]     temp;
  } mft_frame_t;

endpackage

[hw/rtl/mft_if.sv]
// Channel interfaces of the motor feedback multiturn tracker.
// Depends on mft_pkg for field widths.
interface mft_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [mft_pkg::BUS_W-1:0]     bus_number;
  logic [mft_pkg::ID_W-1:0]      frame_id;
  logic [mft_pkg::PAYLOAD_W-1:0] payload;

  modport source (output valid, action, bus_number, frame_id, payload, input ready);
  modport sink   (input valid, action, bus_number, frame_id, payload, output ready);
endinterface

interface mft_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              motor_slot;
  logic [mft_pkg::ENC_W-1:0]         encoder_count;
  logic signed [mft_pkg::TURN_W-1:0]  turn_number;
  logic signed [mft_pkg::TOTAL_W-1:0] total_position;
  logic signed [mft_pkg::WORD_W-1:0]  shaft_speed;
  logic signed [mft_pkg::WORD_W-1:0]  winding_current;
  logic [mft_pkg::BYTE_W-1:0]        temperature;
  logic [mft_pkg::MOTOR_SLOTS-1:0]   online_mask;
  logic                              all_online;

  modport source (output valid, accepted, motor_slot, encoder_count, turn_number,
                  total_position, shaft_speed, winding_current, temperature,
                  online_mask, all_online, input ready);
  modport sink   (input valid, accepted, motor_slot, encoder_count, turn_number,
                  total_position, shaft_speed, winding_current, temperature,
                  online_mask, all_online, output ready);
endinterface

[hw/rtl/mft_frame_decode.sv]
// Frame filter and payload parser of the motor feedback multiturn tracker.
// Depends on mft_pkg; purely combinational.
module mft_frame_decode (
  input  logic                          action,
  input  logic [mft_pkg::BUS_W-1:0]     bus_number,
  input  logic [mft_pkg::ID_W-1:0]      frame_id,
  input  logic [mft_pkg::PAYLOAD_W-1:0] payload,
  input  mft_pkg::mft_cfg_t             cfg,
  output mft_pkg::mft_frame_t           frame
);

  logic [mft_pkg::ID_W:0]      id_lo;
  logic [mft_pkg::ID_W:0]      id_hi;
  logic [mft_pkg::ID_W:0]      id_ext;
  logic [mft_pkg::ID_W-1:0]    id_offset;
  logic [mft_pkg::MOTOR_W-1:0] motor_num;
  logic                        is_feedback;
  logic                        yaw_match;
  logic                        pitch_match;

  // The window is one past the base up to seven past it, on 12 bits so that
  // a base near the top of the identifier space cannot wrap.
  assign id_ext      = {1'b0, frame_id};
  assign id_lo       = {1'b0, cfg.id_base} + (mft_pkg::ID_W + 1)'(1);
  assign id_hi       = {1'b0, cfg.id_base} + (mft_pkg::ID_W + 1)'(7);
  assign id_offset   = frame_id - cfg.id_base;
  assign motor_num   = id_offset[mft_pkg::MOTOR_W-1:0];

  assign is_feedback = (action == mft_pkg::ACTION_FRAME) &&
                       (bus_number == mft_pkg::BUS_FEEDBACK) &&
                       (id_ext >= id_lo) && (id_ext <= id_hi);

  // Inside the window the motor number is never zero, so an id of zero never matches.
  assign yaw_match   = (motor_num == cfg.yaw_id);
  assign pitch_match = (motor_num == cfg.pitch_id);

  always_comb begin
    frame.hit     = is_feedback && (yaw_match || pitch_match);
    frame.slot    = yaw_match ? 1'b0 : 1'b1;
    frame.enc     = payload[40 +: mft_pkg::ENC_W];
    frame.speed   = payload[24 +: mft_pkg::WORD_W];
    frame.current = payload[8 +: mft_pkg::WORD_W];
    frame.temp    = payload[0 +: mft_pkg::BYTE_W];
  end

endmodule

[hw/rtl/motor_feedback_multiturn_tracker.sv]
// Top level of the motor feedback multiturn tracker.
// Depends on mft_pkg, the channel interfaces in mft_if and mft_frame_decode.
//
//  Channel   | Direction | Handshake        | Carries
//  ----------+-----------+------------------+----------------------------------------
//  in_chan   | sink      | valid/ready      | action, bus, identifier, 7 data bytes
//  out_chan  | source    | valid/ready      | one result per input transfer
//  cfg_*     | input     | write enable     | register index and write data, no wait
//
// An input transfer lands in the input register; from there the decode, turn update and
// timeout checks run in one pass and load the result register, so each result passes
// through both registers; one item is taken every cycle while the result is not stalled.
// The state updates as the item leaves the input register, so the next item always sees it.
// A stalled result lets the input register take one more transfer before ready drops. Reset
// restores the configuration defaults and clears the counters, state flags and valid bits.
module motor_feedback_multiturn_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  mft_in_if.sink                          in_chan,
  mft_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [mft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mft_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned NS = mft_pkg::MOTOR_SLOTS;

  // Configuration registers.
  mft_pkg::mft_cfg_t cfg_r;

  // Input register.
  logic                          in_valid_r;
  logic                          in_action_r;
  logic [mft_pkg::BUS_W-1:0]     in_bus_r;
  logic [mft_pkg::ID_W-1:0]      in_id_r;
  logic [mft_pkg::PAYLOAD_W-1:0] in_payload_r;

  // Tracker state.
  logic [mft_pkg::TIME_W-1:0] ms_r, ms_nxt;
  logic [mft_pkg::ENC_W-1:0]  enc_r    [NS];
  logic [mft_pkg::ENC_W-1:0]  enc_nxt  [NS];
  logic [mft_pkg::TURN_W-1:0] turn_r   [NS];
  logic [mft_pkg::TURN_W-1:0] turn_nxt [NS];
  logic [mft_pkg::TIME_W-1:0] seen_time_r   [NS];
  logic [mft_pkg::TIME_W-1:0] seen_time_nxt [NS];
  logic [NS-1:0]              seen_r, seen_nxt;
  logic [NS-1:0]              online_r, online_nxt;

  // Result register.
  logic                               out_valid_r;
  logic                               out_accepted_r;
  logic                               out_slot_r;
  logic [mft_pkg::ENC_W-1:0]          out_enc_r;
  logic [mft_pkg::TURN_W-1:0]         out_turn_r;
  logic [mft_pkg::WORD_W-1:0]         out_speed_r;
  logic [mft_pkg::WORD_W-1:0]         out_current_r;
  logic [mft_pkg::BYTE_W-1:0]         out_temp_r;
  logic [NS-1:0]                      out_mask_r;
  logic                               out_all_r;

  logic                       advance;
  logic                       fire;
  logic                       is_tick;
  mft_pkg::mft_frame_t        frame;
  logic [mft_pkg::ENC_W-1:0]  enc_old;
  logic [mft_pkg::TURN_W-1:0] turn_old;
  logic                       seen_old;
  logic signed [mft_pkg::ENC_W:0] enc_diff;
  logic [mft_pkg::TURN_W-1:0] turn_upd;
  logic [mft_pkg::TIME_W-1:0] ms_inc;

  // The pass advances whenever the result register is empty or being drained.
  assign advance       = !out_valid_r || out_chan.ready;
  assign fire          = in_valid_r && advance;
  assign in_chan.ready = !in_valid_r || advance;

  // Configuration writes; software must write only while the block is idle; unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yaw_id   <= mft_pkg::RST_YAW_ID;
      cfg_r.pitch_id <= mft_pkg::RST_PITCH_ID;
      cfg_r.id_base  <= mft_pkg::RST_ID_BASE;
      cfg_r.timeout  <= mft_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      case (mft_pkg::cfg_reg_t'(cfg_index))
        mft_pkg::REG_YAW_ID:   cfg_r.yaw_id   <= cfg_wdata[mft_pkg::MOTOR_W-1:0];
        mft_pkg::REG_PITCH_ID: cfg_r.pitch_id <= cfg_wdata[mft_pkg::MOTOR_W-1:0];
        mft_pkg::REG_ID_BASE:  cfg_r.id_base  <= cfg_wdata[mft_pkg::ID_W-1:0];
        mft_pkg::REG_TIMEOUT:  cfg_r.timeout  <= cfg_wdata[mft_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: loads on every input transfer, empties when the pass fires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_action_r  <= in_chan.action;
      in_bus_r     <= in_chan.bus_number;
      in_id_r      <= in_chan.frame_id;
      in_payload_r <= in_chan.payload;
    end
  end

  mft_frame_decode u_decode (
    .action     (in_action_r),
    .bus_number (in_bus_r),
    .frame_id   (in_id_r),
    .payload    (in_payload_r),
    .cfg        (cfg_r),
    .frame      (frame)
  );

  assign is_tick  = (in_action_r == mft_pkg::ACTION_TICK);
  assign ms_inc   = ms_r + mft_pkg::TIME_W'(1);
  assign enc_old  = enc_r[frame.slot];
  assign turn_old = turn_r[frame.slot];
  assign seen_old = seen_r[frame.slot];

  // A jump of more than half a turn between two samples is taken as a wrap.
  // The first frame of a slot only records its position.
  assign enc_diff = $signed({1'b0, frame.enc}) - $signed({1'b0, enc_old});

  always_comb begin
    turn_upd = turn_old;
    if (seen_old) begin
      if (enc_diff > mft_pkg::ENC_HALF_TURN) begin
        turn_upd = turn_old - mft_pkg::TURN_W'(1);
      end else if (enc_diff < -mft_pkg::ENC_HALF_TURN) begin
        turn_upd = turn_old + mft_pkg::TURN_W'(1);
      end
    end
  end

  // State next values. A tick bumps the counter first and then ages each slot
  // against the new count, modulo 2^32; a matching frame refreshes one slot.
  always_comb begin
    ms_nxt     = ms_r;
    seen_nxt   = seen_r;
    online_nxt = online_r;
    for (int i = 0; i < NS; i++) begin
      enc_nxt[i]       = enc_r[i];
      turn_nxt[i]      = turn_r[i];
      seen_time_nxt[i] = seen_time_r[i];
    end
    if (fire) begin
      if (is_tick) begin
        ms_nxt = ms_inc;
        for (int i = 0; i < NS; i++) begin
          if ((ms_inc - seen_time_r[i]) >
              {{(mft_pkg::TIME_W - mft_pkg::TIMEOUT_W){1'b0}}, cfg_r.timeout}) begin
            online_nxt[i] = 1'b0;
          end
        end
      end else if (frame.hit) begin
        for (int i = 0; i < NS; i++) begin
          if (frame.slot == mft_pkg::SLOT_W'(i)) begin
            enc_nxt[i]       = frame.enc;
            turn_nxt[i]      = turn_upd;
            seen_time_nxt[i] = ms_r;
            seen_nxt[i]      = 1'b1;
            online_nxt[i]    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r     <= '0;
      seen_r   <= '0;
      online_r <= '0;
      for (int i = 0; i < NS; i++) begin
        enc_r[i]       <= '0;
        turn_r[i]      <= '0;
        seen_time_r[i] <= '0;
      end
    end else begin
      ms_r     <= ms_nxt;
      seen_r   <= seen_nxt;
      online_r <= online_nxt;
      for (int i = 0; i < NS; i++) begin
        enc_r[i]       <= enc_nxt[i];
        turn_r[i]      <= turn_nxt[i];
        seen_time_r[i] <= seen_time_nxt[i];
      end
    end
  end

  // Result register. Ticks and rejected frames report zeros except the flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted_r <= frame.hit && !is_tick;
      out_mask_r     <= online_nxt;
      out_all_r      <= &online_nxt;
      if (frame.hit && !is_tick) begin
        out_slot_r    <= frame.slot;
        out_enc_r     <= frame.enc;
        out_turn_r    <= turn_upd;
        out_speed_r   <= frame.speed;
        out_current_r <= frame.current;
        out_temp_r    <= frame.temp;
      end else begin
        out_slot_r    <= 1'b0;
        out_enc_r     <= '0;
        out_turn_r    <= '0;
        out_speed_r   <= '0;
        out_current_r <= '0;
        out_temp_r    <= '0;
      end
    end
  end

  // The encoder count is below one turn, so turns*8192 + count is a concatenation.
  assign out_chan.valid            = out_valid_r;
  assign out_chan.accepted         = out_accepted_r;
  assign out_chan.motor_slot       = out_slot_r;
  assign out_chan.encoder_count    = out_enc_r;
  assign out_chan.turn_number      = $signed(out_turn_r);
  assign out_chan.total_position   = $signed({out_turn_r, out_enc_r});
  assign out_chan.shaft_speed      = $signed(out_speed_r);
  assign out_chan.winding_current  = $signed(out_current_r);
  assign out_chan.temperature      = out_temp_r;
  assign out_chan.online_mask      = out_mask_r;
  assign out_chan.all_online       = out_all_r;

endmodule
